// File: rtl/core/pbosc_pkg.sv
package pbosc_pkg;

    // sample format: Q2.FRAC_BITS waves, Q3.FRAC_BITS mix
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = SAMPLE_BITS - 1;
    localparam int WAVE_W      = FRAC_BITS + 3;
    localparam int BLEP_W      = FRAC_BITS + 2;
    localparam int ACC_W       = FRAC_BITS + 7;
    localparam int OUT_W       = FRAC_BITS + 4;

    // port field widths
    localparam int ACTION_W    = 2;
    localparam int INC_W       = 23;
    localparam int LFO_W       = 16;
    localparam int NOISE_W     = 16;
    localparam int START_W     = 24;
    localparam int LEVEL_W     = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // shared multiplier
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // 0.4 in Q0.16 and the scaling of the width modulation product
    localparam int PWM_SCALE   = 26214;
    localparam int PWM_SH_BASE = 46;
    localparam int LEVEL_SHIFT = 15;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_NOTE_ON = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PULSE_WIDTH = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PWM_DEPTH   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LFO_TO_PWM  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SAW_LEVEL   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PULSE_LEVEL = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SUB_LEVEL   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_NOISE_LEVEL = 3'd6;

    // register reset values
    localparam logic [LEVEL_W-1:0] PULSE_WIDTH_RST = 16'd32768;
    localparam logic [LEVEL_W-1:0] SAW_LEVEL_RST   = 16'd32768;

    typedef logic signed [WAVE_W-1:0] t_wave;
    typedef logic signed [BLEP_W-1:0] t_blep;
    typedef logic        [LEVEL_W-1:0] t_level;

endpackage

// File: rtl/core/polyblep_mixed_oscillator.sv
// Channel   Direction  Handshake           Payload
// input     in         i_valid / o_stall   i_action, i_phase_inc, i_lfo_value,
//                                          i_noise_sample, i_start_main_phase,
//                                          i_start_sub_phase
// output    out        o_valid / i_stall   o_sample
// config    in         i_cfg_we            i_cfg_index, i_cfg_data
//
// A note-on or phase-reset beat is taken without leaving the idle state. A tick keeps
// the block busy through the width modulation product (when enabled), the width, each
// of the two bleps (region test, restoring divider steps, square) and the four mix
// products on the one shared multiplier, then the loading of the result.
// Synchronous active-low reset clears the phases and loads register defaults.
// o_stall is high while a tick is in work; a finished result waits in the output
// register, and a tick only holds in its output state while it is full and stalled.
module polyblep_mixed_oscillator #(
    parameter int PHASE_BITS = 24
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input beats
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [pbosc_pkg::ACTION_W-1:0]         i_action,
    input  logic [pbosc_pkg::INC_W-1:0]            i_phase_inc,
    input  logic signed [pbosc_pkg::LFO_W-1:0]     i_lfo_value,
    input  logic signed [pbosc_pkg::NOISE_W-1:0]   i_noise_sample,
    input  logic [pbosc_pkg::START_W-1:0]          i_start_main_phase,
    input  logic [pbosc_pkg::START_W-1:0]          i_start_sub_phase,
    // result beats
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [pbosc_pkg::OUT_W-1:0]     o_sample,
    // configuration writes
    input  logic                                   i_cfg_we,
    input  logic [pbosc_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [pbosc_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int FB      = pbosc_pkg::FRAC_BITS;
    localparam int WID_W   = PHASE_BITS + 3;
    localparam int PWM_SH  = pbosc_pkg::PWM_SH_BASE - PHASE_BITS;
    localparam int BASE_SH = PHASE_BITS - 16;
    localparam int CNT_W   = $clog2(FB);
    localparam int PW      = pbosc_pkg::PROD_W;

    localparam longint unsigned SPAN   = 64'd1 << PHASE_BITS;
    localparam longint unsigned W_LO_U = (64'd5 * SPAN + 64'd50) / 64'd100;
    localparam longint unsigned W_HI_U = (64'd95 * SPAN + 64'd50) / 64'd100;

    localparam logic signed [WID_W-1:0]    W_LO    = WID_W'(W_LO_U);
    localparam logic signed [WID_W-1:0]    W_HI    = WID_W'(W_HI_U);
    localparam logic [PHASE_BITS-1:0]      W_LO_P  = PHASE_BITS'(W_LO_U);
    localparam logic [PHASE_BITS-1:0]      W_HI_P  = PHASE_BITS'(W_HI_U);
    localparam logic [PHASE_BITS:0]        SPAN_P1 = (PHASE_BITS + 1)'(SPAN);
    localparam logic signed [PW-1:0]       PWM_RND = PW'((64'd1 << PWM_SH) - 64'd1);
    localparam logic signed [PW-1:0]       LVL_RND =
        PW'((64'd1 << pbosc_pkg::LEVEL_SHIFT) - 64'd1);
    localparam logic [FB:0]                ONE_U   = (FB + 1)'(64'd1 << FB);
    localparam logic signed [pbosc_pkg::WAVE_W-1:0] ONE_W =
        pbosc_pkg::WAVE_W'(64'd1 << FB);
    localparam logic signed [pbosc_pkg::ACC_W-1:0] SAT_HI =
        pbosc_pkg::ACC_W'((64'd4 << FB) - 64'd1);
    localparam logic signed [pbosc_pkg::ACC_W-1:0] SAT_LO =
        -pbosc_pkg::ACC_W'(64'd4 << FB);
    localparam logic [CNT_W-1:0]           DIV_LAST = CNT_W'(FB - 1);

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_PWM_A    = 4'd1;
    localparam logic [3:0] S_PWM_B    = 4'd2;
    localparam logic [3:0] S_WIDTH    = 4'd3;
    localparam logic [3:0] S_BLEP_SET = 4'd4;
    localparam logic [3:0] S_DIV      = 4'd5;
    localparam logic [3:0] S_SQUARE   = 4'd6;
    localparam logic [3:0] S_BLEP_END = 4'd7;
    localparam logic [3:0] S_MIX_MUL  = 4'd8;
    localparam logic [3:0] S_MIX_ACC  = 4'd9;
    localparam logic [3:0] S_OUT      = 4'd10;

    // mix part order
    localparam logic [1:0] MIX_SAW   = 2'd0;
    localparam logic [1:0] MIX_PULSE = 2'd1;
    localparam logic [1:0] MIX_SUB   = 2'd2;
    localparam logic [1:0] MIX_NOISE = 2'd3;

    logic [3:0]                          r_state;
    pbosc_pkg::t_level                   r_pulse_width;
    pbosc_pkg::t_level                   r_pwm_depth;
    logic                                r_lfo_to_pwm;
    pbosc_pkg::t_level                   r_saw_level;
    pbosc_pkg::t_level                   r_pulse_level;
    pbosc_pkg::t_level                   r_sub_level;
    pbosc_pkg::t_level                   r_noise_level;
    logic [PHASE_BITS-1:0]               r_main_phase;
    logic [PHASE_BITS-1:0]               r_sub_phase;
    logic [PHASE_BITS-1:0]               r_inc;
    logic signed [pbosc_pkg::LFO_W-1:0]  r_lfo;
    logic signed [pbosc_pkg::NOISE_W-1:0] r_noise;
    logic signed [PW-1:0]                r_prod;
    logic [PHASE_BITS-1:0]               r_width;
    logic [PHASE_BITS-1:0]               r_rem;
    logic [FB-1:0]                       r_quo;
    logic                                r_neg;
    logic                                r_sel;
    logic [CNT_W-1:0]                    r_cnt;
    pbosc_pkg::t_blep                    r_blep0;
    pbosc_pkg::t_blep                    r_blep1;
    logic signed [pbosc_pkg::ACC_W-1:0]  r_acc;
    logic signed [pbosc_pkg::OUT_W-1:0]  r_sample;
    logic                                r_out_valid;

    logic                                in_take;
    logic                                out_load;
    logic [63:0]                         inc_ext;
    logic [63:0]                         start_main_ext;
    logic [63:0]                         start_sub_ext;
    logic [PHASE_BITS-1:0]               inc_in;
    logic [PHASE_BITS-1:0]               start_main;
    logic [PHASE_BITS-1:0]               start_sub;

    logic signed [pbosc_pkg::MUL_A_W-1:0] mul_a;
    logic signed [pbosc_pkg::MUL_B_W-1:0] mul_b;
    logic signed [PW-1:0]                mul_p;

    logic [PHASE_BITS-1:0]               base_scaled;
    logic signed [PW-1:0]                pwm_q;
    logic signed [WID_W-1:0]             wid_sum;
    logic signed [WID_W-1:0]             wid_clamp;
    logic [PHASE_BITS-1:0]               width_next;

    logic [PHASE_BITS-1:0]               t_sel;
    logic                                t_below;
    logic                                t_above;
    logic [PHASE_BITS:0]                 t_sum;
    logic [PHASE_BITS:0]                 t_top;
    logic [PHASE_BITS-1:0]               numer;
    logic [PHASE_BITS:0]                 rem2;
    logic [PHASE_BITS:0]                 rem_sub;
    logic                                rem_ge;
    logic [FB:0]                         blep_d;
    logic [FB:0]                         blep_mag;
    pbosc_pkg::t_blep                    blep_val;

    pbosc_pkg::t_wave                    blep0_w;
    pbosc_pkg::t_wave                    blep1_w;
    pbosc_pkg::t_wave                    saw_w;
    pbosc_pkg::t_wave                    pulse_w;
    pbosc_pkg::t_wave                    sub_w;
    pbosc_pkg::t_wave                    noise_w;
    pbosc_pkg::t_wave                    wave_sel;
    pbosc_pkg::t_level                   level_sel;
    logic signed [PW-1:0]                mix_q;
    logic signed [pbosc_pkg::ACC_W-1:0]  sat;

    // handshake
    assign in_take  = i_valid && (r_state == S_IDLE);
    assign o_stall  = (r_state != S_IDLE);
    assign out_load = (r_state == S_OUT) && (!r_out_valid || !i_stall);
    assign o_valid  = r_out_valid;
    assign o_sample = r_sample;

    // input fields taken as Q0.P
    assign inc_ext        = 64'(i_phase_inc);
    assign start_main_ext = 64'(i_start_main_phase);
    assign start_sub_ext  = 64'(i_start_sub_phase);
    assign inc_in         = inc_ext[PHASE_BITS-1:0];
    assign start_main     = start_main_ext[PHASE_BITS-1:0];
    assign start_sub      = start_sub_ext[PHASE_BITS-1:0];

    // pulse width: base, or base plus modulation clamped to 0.05..0.95
    always_comb begin
        base_scaled = PHASE_BITS'(r_pulse_width) << BASE_SH;
        pwm_q       = (r_prod + (r_prod[PW-1] ? PWM_RND : '0)) >>> PWM_SH;
        wid_sum     = $signed({3'b000, base_scaled}) + $signed(pwm_q[WID_W-1:0]);
        if (wid_sum < W_LO) begin
            wid_clamp = W_LO;
        end else if (wid_sum > W_HI) begin
            wid_clamp = W_HI;
        end else begin
            wid_clamp = wid_sum;
        end
        width_next = r_lfo_to_pwm ? wid_clamp[PHASE_BITS-1:0] : base_scaled;
    end

    // blep region test and divider step
    always_comb begin
        t_sel    = r_sel ? (r_main_phase - r_width) : r_main_phase;
        t_below  = (t_sel < r_inc);
        t_sum    = {1'b0, t_sel} + {1'b0, r_inc};
        t_above  = (t_sum > SPAN_P1);
        t_top    = SPAN_P1 - {1'b0, t_sel};
        numer    = t_below ? t_sel : t_top[PHASE_BITS-1:0];
        rem2     = {r_rem, 1'b0};
        rem_ge   = (rem2 >= {1'b0, r_inc});
        rem_sub  = rem2 - {1'b0, r_inc};
        blep_d   = ONE_U - {1'b0, r_quo};
        blep_mag = r_prod[2*FB:FB];
        blep_val = r_neg ? -$signed({1'b0, blep_mag}) : $signed({1'b0, blep_mag});
    end

    // waves and mix selection
    always_comb begin
        blep0_w = $signed({r_blep0[pbosc_pkg::BLEP_W-1], r_blep0});
        blep1_w = $signed({r_blep1[pbosc_pkg::BLEP_W-1], r_blep1});
        saw_w   = $signed({2'b00, r_main_phase[PHASE_BITS-1 -: FB + 1]}) - ONE_W - blep0_w;
        pulse_w = ((r_main_phase < r_width) ? ONE_W : -ONE_W) + blep0_w - blep1_w;
        sub_w   = r_sub_phase[PHASE_BITS-1] ? -ONE_W : ONE_W;
        noise_w = $signed({{2{r_noise[pbosc_pkg::NOISE_W-1]}}, r_noise});
        unique case (r_cnt[1:0])
            MIX_SAW: begin
                wave_sel  = saw_w;
                level_sel = r_saw_level;
            end
            MIX_PULSE: begin
                wave_sel  = pulse_w;
                level_sel = r_pulse_level;
            end
            MIX_SUB: begin
                wave_sel  = sub_w;
                level_sel = r_sub_level;
            end
            MIX_NOISE: begin
                wave_sel  = noise_w;
                level_sel = r_noise_level;
            end
            default: begin
                wave_sel  = '0;
                level_sel = '0;
            end
        endcase
        mix_q = (r_prod + (r_prod[PW-1] ? LVL_RND : '0)) >>> pbosc_pkg::LEVEL_SHIFT;
        if (r_acc > SAT_HI) begin
            sat = SAT_HI;
        end else if (r_acc < SAT_LO) begin
            sat = SAT_LO;
        end else begin
            sat = r_acc;
        end
    end

    // shared multiplier operand select
    always_comb begin
        unique case (r_state)
            S_PWM_A: begin
                mul_a = $signed({{(pbosc_pkg::MUL_A_W - pbosc_pkg::LFO_W)
                                  {r_lfo[pbosc_pkg::LFO_W-1]}}, r_lfo});
                mul_b = pbosc_pkg::MUL_B_W'(pbosc_pkg::PWM_SCALE);
            end
            S_PWM_B: begin
                mul_a = r_prod[pbosc_pkg::MUL_A_W-1:0];
                mul_b = $signed({2'b00, r_pwm_depth});
            end
            S_SQUARE: begin
                mul_a = $signed(pbosc_pkg::MUL_A_W'(blep_d));
                mul_b = $signed(pbosc_pkg::MUL_B_W'(blep_d));
            end
            S_MIX_MUL: begin
                mul_a = $signed(pbosc_pkg::MUL_A_W'(level_sel));
                mul_b = wave_sel;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_width <= pbosc_pkg::PULSE_WIDTH_RST;
            r_pwm_depth   <= '0;
            r_lfo_to_pwm  <= 1'b0;
            r_saw_level   <= pbosc_pkg::SAW_LEVEL_RST;
            r_pulse_level <= '0;
            r_sub_level   <= '0;
            r_noise_level <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pbosc_pkg::REG_PULSE_WIDTH: r_pulse_width <= i_cfg_data;
                pbosc_pkg::REG_PWM_DEPTH:   r_pwm_depth   <= i_cfg_data;
                pbosc_pkg::REG_LFO_TO_PWM:  r_lfo_to_pwm  <= i_cfg_data[0];
                pbosc_pkg::REG_SAW_LEVEL:   r_saw_level   <= i_cfg_data;
                pbosc_pkg::REG_PULSE_LEVEL: r_pulse_level <= i_cfg_data;
                pbosc_pkg::REG_SUB_LEVEL:   r_sub_level   <= i_cfg_data;
                pbosc_pkg::REG_NOISE_LEVEL: r_noise_level <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_sample <= sat[pbosc_pkg::OUT_W-1:0];
        end
    end

    // sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_main_phase <= '0;
            r_sub_phase  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        unique case (i_action)
                            pbosc_pkg::ACT_TICK: begin
                                r_inc   <= inc_in;
                                r_lfo   <= i_lfo_value;
                                r_noise <= i_noise_sample;
                                r_acc   <= '0;
                                r_sel   <= 1'b0;
                                r_state <= r_lfo_to_pwm ? S_PWM_A : S_WIDTH;
                            end
                            pbosc_pkg::ACT_NOTE_ON: begin
                                r_main_phase <= start_main;
                                r_sub_phase  <= start_sub;
                            end
                            pbosc_pkg::ACT_CLEAR: begin
                                r_main_phase <= '0;
                                r_sub_phase  <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_PWM_A: begin
                    r_prod  <= mul_p;
                    r_state <= S_PWM_B;
                end
                S_PWM_B: begin
                    r_prod  <= mul_p;
                    r_state <= S_WIDTH;
                end
                S_WIDTH: begin
                    r_width <= width_next;
                    r_state <= S_BLEP_SET;
                end
                // pick the blep region; outside both the correction is zero
                S_BLEP_SET: begin
                    if (t_below || t_above) begin
                        r_rem   <= numer;
                        r_neg   <= t_below;
                        r_quo   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else if (r_sel) begin
                        r_blep1 <= '0;
                        r_cnt   <= '0;
                        r_state <= S_MIX_MUL;
                    end else begin
                        r_blep0 <= '0;
                        r_sel   <= 1'b1;
                    end
                end
                // restoring divide, one quotient bit per cycle
                S_DIV: begin
                    r_rem <= rem_ge ? rem_sub[PHASE_BITS-1:0] : rem2[PHASE_BITS-1:0];
                    r_quo <= {r_quo[FB-2:0], rem_ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DIV_LAST) begin
                        r_state <= S_SQUARE;
                    end
                end
                S_SQUARE: begin
                    r_prod  <= mul_p;
                    r_state <= S_BLEP_END;
                end
                S_BLEP_END: begin
                    if (r_sel) begin
                        r_blep1 <= blep_val;
                        r_cnt   <= '0;
                        r_state <= S_MIX_MUL;
                    end else begin
                        r_blep0 <= blep_val;
                        r_sel   <= 1'b1;
                        r_state <= S_BLEP_SET;
                    end
                end
                S_MIX_MUL: begin
                    r_prod  <= mul_p;
                    r_state <= S_MIX_ACC;
                end
                S_MIX_ACC: begin
                    r_acc <= r_acc + $signed(mix_q[pbosc_pkg::ACC_W-1:0]);
                    if (r_cnt[1:0] == MIX_NOISE) begin
                        r_state <= S_OUT;
                    end else begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= S_MIX_MUL;
                    end
                end
                // phases advance once the sample is loaded into the output register
                S_OUT: begin
                    if (out_load) begin
                        r_main_phase <= r_main_phase + r_inc;
                        r_sub_phase  <= r_sub_phase + (r_inc >> 1);
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // divider remainder stays below the increment
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_inc))
        else $error("divider remainder out of range");

    // modulated width lies inside the clamp limits
    a_width_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BLEP_SET && r_lfo_to_pwm) |->
        (r_width >= W_LO_P && r_width <= W_HI_P))
        else $error("pulse width outside clamp");

    // a result appears only from the output state
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == S_OUT))
        else $error("result loaded outside output state");

    // note-on loads the start phases
    a_note_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && i_action == pbosc_pkg::ACT_NOTE_ON) |=>
        (r_main_phase == $past(start_main) && r_sub_phase == $past(start_sub)))
        else $error("note-on phase load mismatch");

endmodule

// File: tb/sv/polyblep_mixed_oscillator_tb.sv
`timescale 1ns / 1ps

module polyblep_mixed_oscillator_tb;
    import pbosc_pkg::*;

    localparam int     PHASE_BITS     = 24;
    localparam int     WAVE_FRAC      = 15;
    localparam longint WAVE_ONE       = 64'sd1 <<< WAVE_FRAC;
    localparam longint PHASE_SPAN     = 64'sd1 <<< PHASE_BITS;
    localparam longint WIDTH_LO       = (5 * PHASE_SPAN + 50) / 100;
    localparam longint WIDTH_HI       = (95 * PHASE_SPAN + 50) / 100;
    localparam longint PWM_GAIN       = 26214;     // 0.4 in Q0.16
    localparam int     PWM_SHIFT      = 46 - PHASE_BITS;
    localparam longint MIX_MAX        = 4 * WAVE_ONE - 1;
    localparam longint MIX_MIN        = -4 * WAVE_ONE;
    localparam logic [ACTION_W-1:0]    ACT_UNUSED = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_NONE   = 3'd7;
    localparam int     SETTLE_CYCLES  = 64;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     RANDOM_PHASES  = 8;
    localparam int     PHASE_ITEMS    = 235;
    localparam int     MAX_REPORTS    = 20;

    // Oscillator predictor: register copies, phase state and the samples still owed
    class osc_mix_model;
        t_level                  pulse_width, pwm_depth;
        t_level                  saw_level, pulse_level, sub_level, noise_level;
        logic                    lfo_to_pwm;
        logic [PHASE_BITS-1:0]   main_phase, sub_phase;
        logic signed [OUT_W-1:0] pending_samples[$];
        int                      mismatches, samples_checked;
        int                      ticks, note_ons, clears, ignored;

        function new();
            pulse_width = PULSE_WIDTH_RST;
            pwm_depth   = '0;
            lfo_to_pwm  = 1'b0;
            saw_level   = SAW_LEVEL_RST;
            pulse_level = '0;
            sub_level   = '0;
            noise_level = '0;
            main_phase  = '0;
            sub_phase   = '0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_PULSE_WIDTH: pulse_width = data;
                REG_PWM_DEPTH:   pwm_depth   = data;
                REG_LFO_TO_PWM:  lfo_to_pwm  = data[0];
                REG_SAW_LEVEL:   saw_level   = data;
                REG_PULSE_LEVEL: pulse_level = data;
                REG_SUB_LEVEL:   sub_level   = data;
                REG_NOISE_LEVEL: noise_level = data;
                default: ;
            endcase
        endfunction

        // polyBLEP correction around a wrap of phase t, increment dt
        function longint edge_fix(longint t, longint dt);
            longint x, d;
            if (t < dt) begin
                x = (t <<< WAVE_FRAC) / dt;
                d = WAVE_ONE - x;
                return -((d * d) >>> WAVE_FRAC);
            end
            if (t + dt > PHASE_SPAN) begin
                x = ((PHASE_SPAN - t) <<< WAVE_FRAC) / dt;
                d = WAVE_ONE - x;
                return (d * d) >>> WAVE_FRAC;
            end
            return 0;
        endfunction

        // Q1.15 level times wave, truncated toward zero
        function longint level_mul(longint level, longint wave);
            return (level * wave) / 32768;
        endfunction

        function void take_beat(logic [ACTION_W-1:0] action, logic [INC_W-1:0] inc,
                                logic signed [LFO_W-1:0] lfo,
                                logic signed [NOISE_W-1:0] noise,
                                logic [START_W-1:0] start_main,
                                logic [START_W-1:0] start_sub);
            longint width, ph, dt, saw, pulse, sub, mix;
            case (action)
                ACT_NOTE_ON: begin
                    main_phase = start_main;
                    sub_phase  = start_sub;
                    note_ons++;
                end
                ACT_CLEAR: begin
                    main_phase = '0;
                    sub_phase  = '0;
                    clears++;
                end
                ACT_TICK: begin
                    ph = longint'(main_phase);
                    dt = longint'(inc);
                    // pulse width, modulated and clamped only when the LFO drives it
                    width = longint'(pulse_width) <<< (PHASE_BITS - 16);
                    if (lfo_to_pwm) begin
                        width += (longint'(lfo) * longint'(pwm_depth) * PWM_GAIN)
                                 / (64'sd1 <<< PWM_SHIFT);
                        if (width < WIDTH_LO) width = WIDTH_LO;
                        if (width > WIDTH_HI) width = WIDTH_HI;
                    end
                    saw = (ph >>> (PHASE_BITS - WAVE_FRAC - 1)) - WAVE_ONE - edge_fix(ph, dt);
                    pulse = (ph < width) ? WAVE_ONE : -WAVE_ONE;
                    pulse += edge_fix(ph, dt);
                    pulse -= edge_fix((ph + PHASE_SPAN - width) & (PHASE_SPAN - 1), dt);
                    sub = (longint'(sub_phase) < PHASE_SPAN / 2) ? WAVE_ONE : -WAVE_ONE;
                    mix = level_mul(saw_level, saw) + level_mul(pulse_level, pulse)
                        + level_mul(sub_level, sub) + level_mul(noise_level, longint'(noise));
                    if (mix > MIX_MAX) mix = MIX_MAX;
                    if (mix < MIX_MIN) mix = MIX_MIN;
                    pending_samples.push_back(mix[OUT_W-1:0]);
                    main_phase = main_phase + inc;
                    sub_phase  = sub_phase + (inc >> 1);
                    ticks++;
                end
                default: ignored++;
            endcase
        endfunction

        function void check_sample(logic signed [OUT_W-1:0] got);
            logic signed [OUT_W-1:0] want;
            if (pending_samples.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected sample: expected none, got %0d", $time, got);
                return;
            end
            want = pending_samples.pop_front();
            samples_checked++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: sample mismatch: expected %0d, got %0d", $time, want, got);
            end
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic [ACTION_W-1:0]       i_action = ACT_TICK;
    logic [INC_W-1:0]          i_phase_inc = '0;
    logic signed [LFO_W-1:0]   i_lfo_value = '0;
    logic signed [NOISE_W-1:0] i_noise_sample = '0;
    logic [START_W-1:0]        i_start_main_phase = '0;
    logic [START_W-1:0]        i_start_sub_phase = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic signed [OUT_W-1:0]   o_sample;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data = '0;

    bit           sender_idles = 1'b1;
    bit           receiver_idles = 1'b1;
    int           stall_left = 0;
    int           quiet_cycles = 0;
    int           beats_sent = 0;
    int           settings_applied = 0;
    osc_mix_model osc = new();

    polyblep_mixed_oscillator #(
        .PHASE_BITS(PHASE_BITS)
    ) dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 0;
    end

    // result side: random stall bursts
    always @(negedge i_clk) begin
        if (stall_left == 0 && receiver_idles && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 19);
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // result beats
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            osc.check_sample(o_sample);
    end

    // watchdog: cycles without any accepted beat or register write
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog: no beat for %0d cycles, %0d samples outstanding",
                     $time, quiet_cycles, osc.pending_samples.size());
            $display("polyblep_mixed_oscillator test failed");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        osc.write_reg(index, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_settings(logic [CFG_DATA_W-1:0] width, logic [CFG_DATA_W-1:0] depth,
                                  logic lfo_on, logic [CFG_DATA_W-1:0] saw,
                                  logic [CFG_DATA_W-1:0] pulse, logic [CFG_DATA_W-1:0] sub,
                                  logic [CFG_DATA_W-1:0] noise);
        write_reg(REG_PULSE_WIDTH, width);
        write_reg(REG_PWM_DEPTH, depth);
        write_reg(REG_LFO_TO_PWM, {15'd0, lfo_on});
        write_reg(REG_SAW_LEVEL, saw);
        write_reg(REG_PULSE_LEVEL, pulse);
        write_reg(REG_SUB_LEVEL, sub);
        write_reg(REG_NOISE_LEVEL, noise);
        // unmapped index, must leave everything alone
        write_reg(REG_NONE, 16'($urandom));
        settings_applied++;
    endtask

    // one input beat; valid holds until accepted, optional gap before it
    task automatic send_beat(logic [ACTION_W-1:0] action, logic [INC_W-1:0] inc,
                             logic signed [LFO_W-1:0] lfo, logic signed [NOISE_W-1:0] noise,
                             logic [START_W-1:0] start_main, logic [START_W-1:0] start_sub);
        int gap;
        if (sender_idles && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid            <= 1'b1;
        i_action           <= action;
        i_phase_inc        <= inc;
        i_lfo_value        <= lfo;
        i_noise_sample     <= noise;
        i_start_main_phase <= start_main;
        i_start_sub_phase  <= start_sub;
        do @(posedge i_clk); while (o_stall);
        osc.take_beat(action, inc, lfo, noise, start_main, start_sub);
        beats_sent++;
    endtask

    // hold the sender until every owed sample is out, then let the block settle
    task automatic drain_and_settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (osc.pending_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_setting();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return 16'h8000;
            2: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [INC_W-1:0] pick_inc();
        case ($urandom_range(0, 15))
            0: return '0;
            1, 2: return 23'h7FFFFF - 23'($urandom_range(0, 255));
            3, 4, 5, 6: return 23'($urandom_range(1, 2000));
            7, 8, 9: return 23'($urandom_range(2000, 200000));
            default: return 23'($urandom);
        endcase
    endfunction

    function automatic logic signed [LFO_W-1:0] pick_lfo();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return '0;
            default: return 16'($urandom);
        endcase
    endfunction

    // start phases near the wrap, the pulse edge or the sub edge, or anywhere
    function automatic logic [START_W-1:0] pick_phase();
        logic [START_W-1:0] near;
        near = 24'($urandom_range(0, 4095));
        case ($urandom_range(0, 5))
            0: return -near;
            1: return {osc.pulse_width, 8'h00} - near + 24'd2048;
            2: return 24'h800000 - near + 24'd2048;
            3: return near;
            default: return 24'($urandom);
        endcase
    endfunction

    // optional note-on followed by a run of mostly ticks, with occasional clears, unused actions and note-ons mixed in
    task automatic run_random(int items);
        int                  sent, run_len;
        logic [INC_W-1:0]    inc;
        logic [ACTION_W-1:0] act;
        sent = 0;
        while (sent < items) begin
            inc = pick_inc();
            if ($urandom_range(0, 3) != 0) begin
                send_beat(ACT_NOTE_ON, pick_inc(), pick_lfo(), 16'($urandom),
                          pick_phase(), pick_phase());
                sent++;
            end
            run_len = $urandom_range(4, 60);
            repeat (run_len) begin
                case ($urandom_range(0, 39))
                    0: act = ACT_CLEAR;
                    1: act = ACT_UNUSED;
                    2: act = ACT_NOTE_ON;
                    default: act = ACT_TICK;
                endcase
                if ($urandom_range(0, 9) == 0) inc = pick_inc();
                send_beat(act, inc, pick_lfo(), 16'($urandom), pick_phase(), pick_phase());
                if (act != ACT_UNUSED) sent++;
            end
        end
    endtask

    initial begin
        int p;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: saw only
        send_beat(ACT_TICK, '0, '0, '0, '0, '0);
        send_beat(ACT_TICK, 23'd1, 16'sh7FFF, 16'sh7FFF, 24'hFFFFFF, 24'hFFFFFF);
        send_beat(ACT_TICK, 23'h7FFFFF, 16'sh8000, 16'sh8000, '0, '0);
        drain_and_settle();

        // all four parts at unity, quarter width, LFO on width
        apply_settings(16'h4000, 16'h8000, 1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_beat(ACT_CLEAR, 23'h7FFFFF, 16'sh7FFF, 16'sh7FFF, 24'hFFFFFF, 24'hFFFFFF);
        send_beat(ACT_TICK, '0, '0, '0, '0, '0);
        send_beat(ACT_TICK, 23'd1, 16'sh8000, 16'sh8000, '0, '0);
        send_beat(ACT_TICK, 23'h7FFFFF, 16'sh7FFF, 16'sh7FFF, '0, '0);
        // wrap of the main phase: both sides of the blep
        send_beat(ACT_NOTE_ON, '0, '0, '0, 24'hFFFFFF, 24'h7FFFFF);
        send_beat(ACT_TICK, 23'd1000, '0, '0, '0, '0);
        send_beat(ACT_TICK, 23'd1000, '0, '0, '0, '0);
        send_beat(ACT_UNUSED, 23'h7FFFFF, 16'sh7FFF, 16'sh7FFF, 24'hFFFFFF, 24'hFFFFFF);
        // pulse edge just ahead of the main phase
        send_beat(ACT_NOTE_ON, '0, '0, '0, 24'h3FFFF6, 24'h800000);
        send_beat(ACT_TICK, 23'd100, '0, 16'sh5555, '0, '0);
        send_beat(ACT_TICK, 23'd100, '0, 16'shAAAA, '0, '0);
        send_beat(ACT_TICK, 23'h2AAAAA, 16'sh5555, '0, '0, '0);
        send_beat(ACT_TICK, 23'h555555, 16'shAAAA, '0, '0, '0);
        drain_and_settle();

        // levels above unity: drive the mix into both rails
        apply_settings(16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_beat(ACT_NOTE_ON, '0, '0, '0, 24'hE00000, '0);
        send_beat(ACT_TICK, 23'd64, 16'sh7FFF, 16'sh7FFF, '0, '0);
        send_beat(ACT_NOTE_ON, '0, '0, '0, 24'h400000, 24'h800000);
        send_beat(ACT_TICK, 23'd64, 16'sh8000, 16'sh8000, '0, '0);
        send_beat(ACT_TICK, '0, '0, '0, '0, '0);
        drain_and_settle();

        // random phases, each under its own register setting
        for (p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: apply_settings('0, '0, 1'b0, '0, 16'h8000, '0, '0);
                1: apply_settings(16'hFFFF, 16'h8000, 1'b1, 16'h8000, 16'h8000, 16'h8000,
                                  16'h8000);
                default: apply_settings(pick_setting(), pick_setting(), 1'($urandom),
                                        pick_setting(), pick_setting(), pick_setting(),
                                        pick_setting());
            endcase
            sender_idles   = (p != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            receiver_idles = (p != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            run_random(PHASE_ITEMS);
            drain_and_settle();
        end

        $display("covered %0d input beats: %0d ticks, %0d note-ons, %0d phase clears, %0d unused",
                 beats_sent, osc.ticks, osc.note_ons, osc.clears, osc.ignored);
        $display("%0d samples compared across %0d register settings, %0d mismatches",
                 osc.samples_checked, settings_applied, osc.mismatches);
        if (osc.mismatches == 0 && osc.pending_samples.size() == 0)
            $display("polyblep_mixed_oscillator test passed");
        else
            $display("polyblep_mixed_oscillator test failed");
        $finish;
    end

endmodule
